// ===== hdl/fixed_point_q17_14_alu_macros.svh =====
// Assertion helper macros for the fixed-point ALU
`ifndef FIXED_POINT_Q17_14_ALU_MACROS_SVH
`define FIXED_POINT_Q17_14_ALU_MACROS_SVH

// implication checked on every clock edge outside reset
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the 17.14 fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DIV_W         = 64;

  typedef enum logic [OP_W-1:0] {
    OP_TO_INT_TRUNC = 4'd0,
    OP_TO_INT_ROUND = 4'd1,
    OP_FROM_INT     = 4'd2,
    OP_ADD_FF       = 4'd3,
    OP_SUB_FF       = 4'd4,
    OP_MUL_FF       = 4'd5,
    OP_DIV_FF       = 4'd6,
    OP_ADD_FI       = 4'd7,
    OP_SUB_FI       = 4'd8,
    OP_MUL_FI       = 4'd9,
    OP_DIV_FI       = 4'd10
  } op_e_t;

  // classified work kinds for the back end
  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [OP_W-1:0]          req_type;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     divide_by_zero;
  } out_item_t;

  // classified entry handed from front to back
  typedef struct packed {
    kind_t                    kind;
    logic                     mul_shift;   // scale product down by one unit
    logic                     div_neg;     // quotient sign
    logic                     dz;
    logic [DIV_W-1:0]         dvd_mag;     // dividend magnitude
    logic [DATA_W-1:0]        dvs_mag;     // divisor magnitude
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [DATA_W-1:0] simple_res;
  } work_t;

endpackage

// ===== hdl/fpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Decodes a request, computes the simple operations and prepares the
// operands for the multiply and divide paths.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  in_item_t item,
  output work_t    work
);

  // one unit minus one, used to bias negatives toward zero
  localparam logic signed [DATA_W-1:0] BIAS =
    DATA_W'((64'sd1 <<< FRAC_BITS) - 1);
  // rounding works one bit wider so a +/- half unit cannot wrap
  localparam logic signed [DATA_W:0] HALF_X =
    (DATA_W+1)'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [DATA_W:0] BIAS_X =
    (DATA_W+1)'((64'sd1 <<< FRAC_BITS) - 1);

  logic signed [DATA_W-1:0] a, b, b_sh, trunc_q;
  logic signed [DATA_W:0]   a_x, rnd, rnd_q;
  logic [DATA_W-1:0]        a_mag, b_mag;
  logic signed [DIV_W-1:0]  a_ext;

  always_comb begin
    a       = item.operand_a;
    b       = item.operand_b;
    b_sh    = b <<< FRAC_BITS;
    a_mag   = a[DATA_W-1] ? (~a + 1'b1) : a;
    b_mag   = b[DATA_W-1] ? (~b + 1'b1) : b;
    a_ext   = DIV_W'(a);
    a_x     = (DATA_W+1)'(a);
    // truncating divide by a power of two: bias negatives before shifting
    trunc_q = $signed(a + (a[DATA_W-1] ? BIAS : '0)) >>> FRAC_BITS;
    rnd     = a_x[DATA_W] ? (a_x - HALF_X) : (a_x + HALF_X);
    rnd_q   = $signed(rnd + (rnd[DATA_W] ? BIAS_X : '0)) >>> FRAC_BITS;

    work            = '0;
    work.kind       = K_SIMPLE;
    work.mul_a      = a;
    work.mul_b      = b;
    work.dvs_mag    = b_mag;
    work.div_neg    = a[DATA_W-1] ^ b[DATA_W-1];
    work.dz         = 1'b0;
    work.dvd_mag    = DIV_W'(a_mag);
    unique case (item.req_type)
      OP_TO_INT_TRUNC: work.simple_res = trunc_q;
      OP_TO_INT_ROUND: work.simple_res = rnd_q[DATA_W-1:0];
      OP_FROM_INT:     work.simple_res = b_sh;
      OP_ADD_FF:       work.simple_res = a + b;
      OP_SUB_FF:       work.simple_res = a - b;
      OP_ADD_FI:       work.simple_res = a + b_sh;
      OP_SUB_FI:       work.simple_res = a - b_sh;
      OP_MUL_FF: begin
        work.kind      = K_MUL;
        work.mul_shift = 1'b1;
      end
      OP_MUL_FI: work.kind = K_MUL;
      OP_DIV_FF: begin
        work.kind    = K_DIV;
        work.dz      = (b == '0);
        // |a| * unit, a 64-bit dividend
        work.dvd_mag = (a_ext[DIV_W-1] ? (~a_ext + 1'b1) : a_ext) << FRAC_BITS;
      end
      OP_DIV_FI: begin
        work.kind = K_DIV;
        work.dz   = (b == '0);
      end
      default: work.simple_res = '0;
    endcase
  end

endmodule

// ===== hdl/fpa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_queue
// Short FIFO of classified work between front and back end.
// ----------------------------------------------------------------------------
module fpa_queue import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output logic  empty,
  output logic  full,
  output work_t head
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  work_t           mem_r [QUEUE_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign head  = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hdl/fpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: registered multiply or restoring divide, then
// result register. The divider works one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      w_valid,
  input  work_t     w,
  output logic      w_take,
  output logic      out_strobe,
  output out_item_t out_item
);

  `include "fixed_point_q17_14_alu_macros.svh"

  localparam int CW = $clog2(DIV_W + 1);

  // first stage: multiply, simple results and divide-by-zero
  logic                      mv_r;
  logic                      mshift_r;
  logic                      smul_r;
  logic                      sdz_r;
  logic signed [DATA_W-1:0]  sres_r;
  logic signed [2*DATA_W-1:0] prod_r;
  // divider
  logic                      dbusy_r, dneg_r;
  logic [DIV_W-1:0]          dq_r;
  logic [DATA_W:0]           drem_r;
  logic [DATA_W-1:0]         ddvs_r;
  logic [CW-1:0]             dcnt_r;
  logic                      ddone;
  logic [DATA_W:0]           trial;
  // result register
  logic                      ov_r, ov_nxt;
  out_item_t                 o_r, o_nxt;
  logic signed [2*DATA_W-1:0] pq;
  logic [DIV_W-1:0]          qs;

  // take a queue entry unless the divider is busy
  assign w_take = w_valid && !dbusy_r;
  assign trial  = {drem_r[DATA_W-1:0], dq_r[DIV_W-1]} - {1'b0, ddvs_r};
  assign ddone  = dbusy_r && (dcnt_r == '0);

  // first stage: one registered 32x32 product, or the ready result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= w_take && !(w.kind == K_DIV && !w.dz);
    end
    prod_r   <= (2*DATA_W)'(w.mul_a) * (2*DATA_W)'(w.mul_b);
    mshift_r <= w.mul_shift;
    smul_r   <= (w.kind == K_MUL);
    sdz_r    <= w.dz;
    sres_r   <= w.simple_res;
  end

  // restoring divider, one bit per cycle, then delivers the quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (w_take && w.kind == K_DIV && !w.dz) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= CW'(DIV_W);
      dq_r    <= w.dvd_mag;
      drem_r  <= '0;
      ddvs_r  <= w.dvs_mag;
      dneg_r  <= w.div_neg;
    end else if (dbusy_r) begin
      if (dcnt_r != '0) begin
        if (!trial[DATA_W]) begin
          drem_r <= trial;
          dq_r   <= {dq_r[DIV_W-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[DATA_W-1:0], dq_r[DIV_W-1]};
          dq_r   <= {dq_r[DIV_W-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
      end else begin
        dbusy_r <= 1'b0;
      end
    end
  end

  // result select
  always_comb begin
    pq     = mshift_r ? (prod_r + (prod_r[2*DATA_W-1] ?
             (2*DATA_W)'((64'sd1 <<< FRAC_BITS) - 1) : '0)) >>> FRAC_BITS : prod_r;
    qs     = dneg_r ? (~dq_r + 1'b1) : dq_r;
    ov_nxt = 1'b0;
    o_nxt  = '0;
    if (mv_r) begin
      ov_nxt               = 1'b1;
      o_nxt.result_value   = smul_r ? pq[DATA_W-1:0] : sres_r;
      o_nxt.divide_by_zero = sdz_r;
    end else if (ddone) begin
      ov_nxt             = 1'b1;
      o_nxt.result_value = qs[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    o_r <= o_nxt;
  end

  assign out_strobe = ov_r;
  assign out_item   = o_r;

  `FPA_ASSERT_IMP(a_no_take_busy, clk, rst_n, dbusy_r, !w_take, "took item while dividing")
  `FPA_ASSERT_NEXT(a_mul_out, clk, rst_n, mv_r, ov_r, "multiply result lost")
  `FPA_ASSERT_IMP(a_mul_div, clk, rst_n, mv_r, !ddone, "multiply and divide collide")

endmodule

// ===== hdl/fixed_point_q17_14_alu.sv =====
`timescale 1ns / 1ps
// Path: queue, first-stage register, result register; a divide by a nonzero
// divisor runs the restoring divider instead of the first stage. Throughput:
// one item per cycle while not busy, except division, which holds the back end.
// Reset (rst_n low, synchronous) empties the queue and clears all valid flags.
// Results appear with a one-cycle out_strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// fixed_point_q17_14_alu
// Signed 17.14 fixed-point ALU: decoder front, work queue, execution back end.
// ----------------------------------------------------------------------------
module fixed_point_q17_14_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  work_t work, head;
  logic  q_empty, q_full, take, push;

  assign busy = q_full;
  assign push = start && !busy;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .item (in_item),
    .work (work)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (work),
    .pop       (take),
    .empty     (q_empty),
    .full      (q_full),
    .head      (head)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .w_valid    (!q_empty),
    .w          (head),
    .w_take     (take),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
